@@ src/first_fit_block_allocator_unit_assert.svh @@
// Assertion macros for the first-fit block allocator checker.
// Depends on nothing; included by the checker file only.
`ifndef FIRST_FIT_BLOCK_ALLOCATOR_UNIT_ASSERT_SVH
`define FIRST_FIT_BLOCK_ALLOCATOR_UNIT_ASSERT_SVH

// Same-cycle implication, disabled while reset is high.
`define FFBA_ASSERT_IMP(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("ffba check failed: same-cycle implication");

// Next-cycle implication, disabled while reset is high.
`define FFBA_ASSERT_NXT(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("ffba check failed: next-cycle implication");

`endif

@@ src/ffba_pkg.sv @@
// Shared types and constants of the first-fit block allocator.
// Depends on nothing; used by the cell, the top level and the checker.
package ffba_pkg;

   // Fixed field widths of the transaction payloads
   localparam int INDEX_W  = 5;
   localparam int VALUE_W  = 10;
   localparam int STATUS_W = 2;
   localparam int COUNT_W  = 6;

   // Operation codes carried in req_tuser
   localparam logic FUNC_LOAD  = 1'b0;
   localparam logic FUNC_ALLOC = 1'b1;

   // Result status codes carried in rsp_tuser
   localparam logic [STATUS_W-1:0] ST_LOADED    = 2'd0;
   localparam logic [STATUS_W-1:0] ST_REJECTED  = 2'd1;
   localparam logic [STATUS_W-1:0] ST_ALLOCATED = 2'd2;
   localparam logic [STATUS_W-1:0] ST_NO_MATCH  = 2'd3;

   // Register indexes of the write port
   localparam logic CSR_BLOCK_COUNT = 1'b0;
   localparam logic CSR_MAX_SIZE    = 1'b1;

   localparam logic [VALUE_W-1:0] MAX_SIZE_RESET = 10'd481;

   // Token that walks the cell chain, one cell per cycle
   typedef struct packed {
      logic               valid;
      logic               func;
      logic               load_ok;
      logic [INDEX_W-1:0] index;
      logic [VALUE_W-1:0] value;
      logic               found;
      logic [INDEX_W-1:0] found_idx;
   } token_type;

endpackage

@@ src/ffba_cell.sv @@
// One table entry of the allocator: block size and free mark.
// Depends on ffba_pkg; instantiated in a chain by the top level.
module ffba_cell #(
   parameter int NUM_BLOCKS = 32,
   parameter int SIZE_BITS  = 10
) (
   input  logic                                      clock,
   input  logic                                      reset,
   input  logic [(NUM_BLOCKS > 1 ? $clog2(NUM_BLOCKS) : 1)-1:0] cell_index,
   input  logic [ffba_pkg::COUNT_W-1:0]              block_count,
   input  ffba_pkg::token_type                       tok_in,
   output ffba_pkg::token_type                       tok_out
);

   localparam int IDX_W = (NUM_BLOCKS > 1) ? $clog2(NUM_BLOCKS) : 1;
   localparam int IW    = ffba_pkg::INDEX_W;
   localparam int VW    = ffba_pkg::VALUE_W;
   localparam int CW    = ffba_pkg::COUNT_W;
   localparam int EXT_W = (IDX_W > IW) ? IDX_W : IW;
   localparam int RNG_W = (IDX_W > CW) ? IDX_W : CW;
   localparam int CMP_W = (SIZE_BITS > VW) ? SIZE_BITS : VW;

   logic [SIZE_BITS-1:0] size_ff, size_in;
   logic                 free_ff, free_in;
   ffba_pkg::token_type  token_ff, token_in;
   logic                 in_range, fits, load_hit, alloc_hit;

   // Decode what the passing token does to this entry
   always_comb begin
      fits      = CMP_W'(size_ff) >= CMP_W'(tok_in.value);
      in_range  = RNG_W'(cell_index) < RNG_W'(block_count);
      load_hit  = tok_in.valid && (tok_in.func == ffba_pkg::FUNC_LOAD) &&
                  (EXT_W'(tok_in.index) == EXT_W'(cell_index));
      alloc_hit = tok_in.valid && (tok_in.func == ffba_pkg::FUNC_ALLOC) &&
                  !tok_in.found && in_range && free_ff && fits;
   end

   // Update the entry and mark the token when this block is claimed
   always_comb begin
      size_in  = size_ff;
      free_in  = free_ff;
      token_in = tok_in;
      if (load_hit) begin
         free_in = tok_in.load_ok;
         if (tok_in.load_ok) begin
            size_in = SIZE_BITS'(tok_in.value);
         end
      end
      if (alloc_hit) begin
         free_in            = 1'b0;
         token_in.found     = 1'b1;
         token_in.found_idx = IW'(cell_index);
      end
   end

   // Hold the entry and pass the token on
   always_ff @(posedge clock) begin
      if (reset) begin
         free_ff        <= 1'b0;
         token_ff.valid <= 1'b0;
      end else begin
         free_ff  <= free_in;
         token_ff <= token_in;
      end
      size_ff <= size_in;
   end

   assign tok_out = token_ff;

endmodule

@@ src/first_fit_block_allocator_unit.sv @@
// Top level of the first-fit block allocator: ports, registers, cell chain, result buffer.
// Depends on ffba_pkg and ffba_cell.
//
//  channel | dir | handshake             | payload
//  req     | in  | req_tvalid/req_tready | tdata: block_index, size_value; tuser: func
//  rsp     | out | rsp_tvalid/rsp_tready | tdata: chosen_block, granted_amount; tuser: status
//  csr     | in  | csr_we                | csr_index, csr_wdata
//
// Each transaction walks the chain of NUM_BLOCKS cells, one cell per cycle, and the next
// is accepted only after it has left the chain.
// The result is registered; one more finished result can wait in a holding slot while
// the output is stalled, and then no new transaction is taken.
// Synchronous reset clears all free marks and the handshake state and resets the registers.
module first_fit_block_allocator_unit #(
   parameter int NUM_BLOCKS = 32,
   parameter int SIZE_BITS  = 10
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [15:0] req_tdata,   // [4:0] block_index, [14:5] size_value, [15] zero
   input  logic [0:0]  req_tuser,   // [0] func
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [15:0] rsp_tdata,   // [4:0] chosen_block, [14:5] granted_amount, [15] zero
   output logic [1:0]  rsp_tuser,   // [1:0] status
   input  logic        csr_we,
   input  logic [0:0]  csr_index,
   input  logic [9:0]  csr_wdata
);

   localparam int IDX_W = (NUM_BLOCKS > 1) ? $clog2(NUM_BLOCKS) : 1;
   localparam int IW    = ffba_pkg::INDEX_W;
   localparam int VW    = ffba_pkg::VALUE_W;
   localparam int CW    = ffba_pkg::COUNT_W;
   localparam int SW    = ffba_pkg::STATUS_W;
   localparam int NB_W  = $clog2(NUM_BLOCKS + 1);
   localparam int XW    = (NB_W > IW) ? NB_W : IW;
   localparam int CMP_W = (SIZE_BITS > VW) ? SIZE_BITS : VW;
   localparam logic [CMP_W-1:0] SIZE_MASK = CMP_W'((64'd1 << SIZE_BITS) - 64'd1);

   logic [CW-1:0]       block_count_ff;
   logic [VW-1:0]       max_size_ff;
   logic                inflight_ff, inflight_in;
   logic                pend_valid_ff, pend_valid_in;
   logic [SW-1:0]       pend_user_ff, pend_user_in;
   logic [15:0]         pend_data_ff, pend_data_in;
   logic                out_valid_ff, out_valid_in;
   logic [SW-1:0]       out_user_ff, out_user_in;
   logic [15:0]         out_data_ff, out_data_in;

   ffba_pkg::token_type chain [NUM_BLOCKS+1];
   ffba_pkg::token_type exit_tok;
   logic                accept, value_ok, index_ok, out_free;
   logic [SW-1:0]       exit_user;
   logic [15:0]         exit_data;
   logic [VW-1:0]       granted;

   // Configuration registers
   always_ff @(posedge clock) begin
      if (reset) begin
         block_count_ff <= '0;
         max_size_ff    <= ffba_pkg::MAX_SIZE_RESET;
      end else if (csr_we) begin
         case (csr_index)
            ffba_pkg::CSR_BLOCK_COUNT: block_count_ff <= csr_wdata[CW-1:0];
            ffba_pkg::CSR_MAX_SIZE:    max_size_ff    <= csr_wdata;
            default: ;
         endcase
      end
   end

   // Form the entry token; load checks are settled here
   assign req_tready = !inflight_ff && !pend_valid_ff;
   assign accept     = req_tvalid && req_tready;

   always_comb begin
      value_ok = (CMP_W'(req_tdata[14:5]) <= CMP_W'(max_size_ff)) &&
                 (CMP_W'(req_tdata[14:5]) <= SIZE_MASK);
      index_ok = XW'(req_tdata[4:0]) < XW'(NUM_BLOCKS);
      chain[0].valid     = accept;
      chain[0].func      = req_tuser[0];
      chain[0].load_ok   = value_ok && index_ok;
      chain[0].index     = req_tdata[IW-1:0];
      chain[0].value     = req_tdata[14:5];
      chain[0].found     = 1'b0;
      chain[0].found_idx = '0;
   end

   // Cell chain, one cell per table entry
   for (genvar g = 0; g < NUM_BLOCKS; g++) begin : g_cell
      ffba_cell #(
         .NUM_BLOCKS (NUM_BLOCKS),
         .SIZE_BITS  (SIZE_BITS)
      ) u_cell (
         .clock       (clock),
         .reset       (reset),
         .cell_index  (IDX_W'(g)),
         .block_count (block_count_ff),
         .tok_in      (chain[g]),
         .tok_out     (chain[g+1])
      );
   end

   // Build the result from the token leaving the chain
   assign exit_tok = chain[NUM_BLOCKS];
   assign granted  = VW'(CMP_W'(exit_tok.value) & SIZE_MASK);

   always_comb begin
      exit_user = ffba_pkg::ST_NO_MATCH;
      exit_data = '0;
      if (exit_tok.func == ffba_pkg::FUNC_LOAD) begin
         if (exit_tok.load_ok) begin
            exit_user = ffba_pkg::ST_LOADED;
            exit_data = {1'b0, {VW{1'b0}}, exit_tok.index};
         end else begin
            exit_user = ffba_pkg::ST_REJECTED;
         end
      end else if (exit_tok.found) begin
         exit_user = ffba_pkg::ST_ALLOCATED;
         exit_data = {1'b0, granted, exit_tok.found_idx};
      end
   end

   // Route results through the holding slot and the output register
   always_comb begin
      out_free      = !out_valid_ff || rsp_tready;
      inflight_in   = accept ? 1'b1 : (exit_tok.valid ? 1'b0 : inflight_ff);
      pend_valid_in = pend_valid_ff;
      pend_user_in  = pend_user_ff;
      pend_data_in  = pend_data_ff;
      out_valid_in  = out_valid_ff && !rsp_tready;
      out_user_in   = out_user_ff;
      out_data_in   = out_data_ff;
      if (pend_valid_ff && out_free) begin
         pend_valid_in = 1'b0;
         out_valid_in  = 1'b1;
         out_user_in   = pend_user_ff;
         out_data_in   = pend_data_ff;
      end else if (exit_tok.valid && out_free) begin
         out_valid_in = 1'b1;
         out_user_in  = exit_user;
         out_data_in  = exit_data;
      end else if (exit_tok.valid) begin
         pend_valid_in = 1'b1;
         pend_user_in  = exit_user;
         pend_data_in  = exit_data;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         inflight_ff   <= 1'b0;
         pend_valid_ff <= 1'b0;
         out_valid_ff  <= 1'b0;
      end else begin
         inflight_ff   <= inflight_in;
         pend_valid_ff <= pend_valid_in;
         out_valid_ff  <= out_valid_in;
      end
      pend_user_ff <= pend_user_in;
      pend_data_ff <= pend_data_in;
      out_user_ff  <= out_user_in;
      out_data_ff  <= out_data_in;
   end

   assign rsp_tvalid = out_valid_ff;
   assign rsp_tuser  = out_user_ff;
   assign rsp_tdata  = out_data_ff;

endmodule

@@ src/ffba_checker.sv @@
// Port-level checks of the first-fit block allocator, bound to the top level.
// Depends on ffba_pkg and first_fit_block_allocator_unit_assert.svh.
`include "first_fit_block_allocator_unit_assert.svh"

module ffba_checker (
   input logic        clock,
   input logic        reset,
   input logic        req_tvalid,
   input logic        req_tready,
   input logic        rsp_tvalid,
   input logic        rsp_tready,
   input logic [15:0] rsp_tdata,
   input logic [1:0]  rsp_tuser
);

   // Hold a stalled result transaction
   `FFBA_ASSERT_NXT(a_rsp_hold, clock, reset, rsp_tvalid && !rsp_tready, rsp_tvalid && $stable(rsp_tdata) && $stable(rsp_tuser))

   // Take no new transaction right after one is accepted
   `FFBA_ASSERT_NXT(a_one_at_a_time, clock, reset, req_tvalid && req_tready, !req_tready)

   // Drive zero payload for a rejected load or a failed search
   `FFBA_ASSERT_IMP(a_fail_zero, clock, reset, rsp_tvalid && (rsp_tuser == ffba_pkg::ST_REJECTED || rsp_tuser == ffba_pkg::ST_NO_MATCH), rsp_tdata == 16'd0)

   // Report no granted amount after a load
   `FFBA_ASSERT_IMP(a_load_no_grant, clock, reset, rsp_tvalid && (rsp_tuser == ffba_pkg::ST_LOADED), rsp_tdata[15:5] == 11'd0)

endmodule

bind first_fit_block_allocator_unit ffba_checker u_ffba_checker (.*);
